FILE: design/firdf_pkg.sv
// firdf_pkg: shared widths, codes and controller/datapath interface types
// for the direct-form fir filter. No dependencies.

package firdf_pkg;

  localparam int unsigned MAX_TAPS_DEF   = 32;
  localparam int unsigned COEF_FRAC_BITS = 15;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned TAPCNT_W  = 6;
  localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;

  localparam logic [TAPCNT_W-1:0]        TAPCNT_RST = 6'd15;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sh7FF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_LOAD   = 1'b1
  } firdf_action_e;

  // controller to datapath
  typedef struct packed {
    logic start;      // sample item taken: write history, clear accumulator
    logic load_coef;  // coefficient item taken
    logic issue;      // read one tap pair
    logic finish;     // load the output register
  } firdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;   // output register holds an item that is not taken this cycle
  } firdf_status_t;

endpackage

FILE: design/firdf_ram.sv
// firdf_ram: generic single-write, single-read ram with registered read data.
// No dependencies.

module firdf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/firdf_ctrl.sv
// firdf_ctrl: sequencer for the fir filter; owns the tap_count register,
// the input handshake and the tap loop. Depends on firdf_pkg.

module firdf_ctrl #(
  parameter int unsigned MAX_TAPS = firdf_pkg::MAX_TAPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [firdf_pkg::TAPCNT_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  output firdf_pkg::firdf_cmd_t             cmd_o,
  input  firdf_pkg::firdf_status_t          status_i
);

  import firdf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       remain_q;
  logic                wait_q;
  logic [TAPCNT_W-1:0] tap_count_q;
  logic [CW-1:0]       n_taps;
  logic                accept;

  // clamp to the built tap count
  always_comb begin
    if (32'(tap_count_q) > MAX_TAPS) begin
      n_taps = CW'(MAX_TAPS);
    end else begin
      n_taps = CW'(tap_count_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.start     = accept & (action_i == ACT_SAMPLE);
    cmd_o.load_coef = accept & (action_i == ACT_LOAD);
    cmd_o.issue     = (state_q == ST_RUN);
    cmd_o.finish    = (state_q == ST_DONE) & ~status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      wait_q      <= 1'b0;
      tap_count_q <= TAPCNT_RST;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && (action_i == ACT_SAMPLE)) begin
            remain_q <= n_taps;
            wait_q   <= 1'b0;
            state_q  <= (n_taps == '0) ? ST_WAIT : ST_RUN;
          end
        end
        ST_RUN: begin
          remain_q <= remain_q - 1'b1;
          if (remain_q == CW'(1)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // wait for ram read and multiply to drain into the accumulator
          wait_q <= ~wait_q;
          if (wait_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/firdf_dp.sv
// firdf_dp: fir datapath: history and coefficient rams, one shared
// multiply-accumulate, truncation, saturation and output register.
// Depends on firdf_pkg and firdf_ram.

module firdf_dp #(
  parameter int unsigned MAX_TAPS = firdf_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  firdf_pkg::firdf_cmd_t                  cmd_i,
  output firdf_pkg::firdf_status_t               status_o,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [firdf_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [firdf_pkg::COEF_W-1:0]    coef_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [firdf_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                   clipped_o
);

  import firdf_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int unsigned QW    = ACC_W + 1 - COEF_FRAC_BITS;
  localparam logic [AW-1:0] LAST = AW'(MAX_TAPS - 1);
  localparam logic signed [ACC_W:0] BIAS =
    {{(ACC_W + 1 - COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};

  logic [AW-1:0]               head_q;
  logic [AW-1:0]               head_d;
  logic [AW-1:0]               rp_q;
  logic [AW-1:0]               cidx_q;
  logic [AW-1:0]               coef_waddr;
  logic                        coef_we;
  logic [MAX_TAPS-1:0]         hist_vld_q;
  logic [MAX_TAPS-1:0]         coef_vld_q;
  logic [SAMPLE_W-1:0]         hist_rdata;
  logic [COEF_W-1:0]           coef_rdata;
  logic                        v1_q;
  logic                        v2_q;
  logic                        hv1_q;
  logic                        cv1_q;
  logic signed [SAMPLE_W-1:0]  s_op;
  logic signed [COEF_W-1:0]    c_op;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [ACC_W:0]       biased;
  logic signed [QW-1:0]        quot;
  logic signed [SAMPLE_W-1:0]  sat_val;
  logic                        sat_clip;
  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  sample_out_q;
  logic                        clipped_q;

  // history is a circular buffer; the newest sample sits at head, older ones above it
  assign head_d     = (head_q == '0) ? LAST : head_q - 1'b1;
  assign coef_waddr = AW'(coef_index_i);
  assign coef_we    = cmd_i.load_coef & (32'(coef_index_i) < MAX_TAPS);

  firdf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start),
    .waddr_i (head_d),
    .wdata_i (sample_in_i),
    .raddr_i (rp_q),
    .rdata_o (hist_rdata)
  );

  firdf_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .raddr_i (cidx_q),
    .rdata_o (coef_rdata)
  );

  // entries never written read as zero
  assign s_op = hv1_q ? $signed(hist_rdata) : '0;
  assign c_op = cv1_q ? $signed(coef_rdata) : '0;

  // divide by 2^frac truncating toward zero, then clamp
  assign biased = (ACC_W + 1)'(acc_q) + (acc_q[ACC_W-1] ? BIAS : '0);
  assign quot   = biased[ACC_W:COEF_FRAC_BITS];

  always_comb begin
    if (quot > QW'(SAMPLE_MAX)) begin
      sat_val  = SAMPLE_MAX;
      sat_clip = 1'b1;
    end else if (quot < QW'(SAMPLE_MIN)) begin
      sat_val  = SAMPLE_MIN;
      sat_clip = 1'b1;
    end else begin
      sat_val  = quot[SAMPLE_W-1:0];
      sat_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      rp_q        <= '0;
      cidx_q      <= '0;
      hist_vld_q  <= '0;
      coef_vld_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hv1_q       <= 1'b0;
      cv1_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (cmd_i.start) begin
        head_q             <= head_d;
        rp_q               <= head_d;
        cidx_q             <= '0;
        hist_vld_q[head_d] <= 1'b1;
        acc_q              <= '0;
      end else begin
        if (cmd_i.issue) begin
          rp_q   <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
          cidx_q <= cidx_q + 1'b1;
        end
        if (v2_q) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
      end
      v1_q  <= cmd_i.issue;
      hv1_q <= hist_vld_q[rp_q];
      cv1_q <= coef_vld_q[cidx_q];
      v2_q  <= v1_q;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= s_op * c_op;
    if (cmd_i.finish) begin
      sample_out_q <= sat_val;
      clipped_q    <= sat_clip;
    end
  end

  assign status_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_out_q;
  assign clipped_o         = clipped_q;

endmodule

FILE: design/fir_filter_direct_form_top.sv
// fir_filter_direct_form_top: direct-form fir filter, controller plus datapath.
// Depends on firdf_pkg, firdf_ctrl, firdf_dp, firdf_ram.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   action_i sample_in_i coef_index_i coef_value_i
//   out      output     out_valid_o / out_stall_i sample_out_o clipped_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (tap_count)
//
// a coefficient item gives no result and leaves the input free for the next item.
// a sample item takes one ram read and one multiply-accumulate per tap in use,
// through the single shared multiplier.
// a finished result waits in the output register; the next item is taken meanwhile,
// but a further result waits in the controller until that register is free.
// reset clears the history and coefficient valid bits, so both read as zero.

module fir_filter_direct_form_top #(
  parameter int unsigned MAX_TAPS = firdf_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [firdf_pkg::TAPCNT_W-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   action_i,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [firdf_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [firdf_pkg::COEF_W-1:0]    coef_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [firdf_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                   clipped_o
);

  import firdf_pkg::*;

  firdf_cmd_t    cmd;
  firdf_status_t status;

  firdf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  firdf_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

FILE: design/firdf_chk.sv
// firdf_chk: port-level checks for the fir filter, bound to the top level.
// Depends on firdf_pkg.

module firdf_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   action_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [firdf_pkg::SAMPLE_W-1:0]  sample_out_o,
  input logic                                   clipped_o
);

  import firdf_pkg::*;

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o) && $stable(clipped_o))
    else $error("result changed while stalled");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> (sample_out_o == SAMPLE_MAX) || (sample_out_o == SAMPLE_MIN))
    else $error("clipped result not saturated");

  // a sample item keeps the block busy in the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_SAMPLE) |=> in_stall_o)
    else $error("sample item did not occupy the filter");

  // no result can appear in the cycle after its sample item
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_SAMPLE) |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind fir_filter_direct_form_top firdf_chk u_chk (.*);

FILE: dv/fir_filter_direct_form_checker.sv
// fir_filter_direct_form_checker: watches the channels of the fir filter, predicts
// each filtered sample and compares it with what the block delivers.
// Depends on firdf_pkg.
`timescale 1ns / 1ps

module fir_filter_direct_form_checker #(
  parameter int unsigned MAX_TAPS = firdf_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [firdf_pkg::TAPCNT_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic                                  action_i,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [firdf_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [firdf_pkg::COEF_W-1:0]   coef_value_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0] sample_out_i,
  input  logic                                  clipped_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  import firdf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } fir_output_t;

  logic signed [SAMPLE_W-1:0] history [MAX_TAPS-1];
  logic signed [COEF_W-1:0]   weights [MAX_TAPS];
  logic [TAPCNT_W-1:0]        taps_in_use;
  fir_output_t                expected_outputs [$];
  int                         fails;

  // full-width sum, one division toward zero, then clamp to 12 bits
  function automatic fir_output_t fir_output(logic signed [SAMPLE_W-1:0] x0);
    longint      acc;
    longint      quot;
    longint      tap_sample;
    int unsigned n;
    fir_output_t r;
    acc = 0;
    n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : taps_in_use;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) tap_sample = longint'(x0);
      else tap_sample = longint'(history[i-1]);
      acc += tap_sample * longint'(weights[i]);
    end
    quot = acc / (longint'(1) << COEF_FRAC_BITS);
    r.clipped = 1'b0;
    if (quot > longint'(SAMPLE_MAX)) begin
      r.sample  = SAMPLE_MAX;
      r.clipped = 1'b1;
    end else if (quot < longint'(SAMPLE_MIN)) begin
      r.sample  = SAMPLE_MIN;
      r.clipped = 1'b1;
    end else begin
      r.sample = quot[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fir_output_t exp_out;
    if (!rst_ni) begin
      foreach (history[k]) history[k] = '0;
      foreach (weights[k]) weights[k] = '0;
      taps_in_use = TAPCNT_RST;
      expected_outputs.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) taps_in_use = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ACT_LOAD) begin
          if (coef_index_i < MAX_TAPS) weights[coef_index_i] = coef_value_i;
        end else begin
          expected_outputs.push_back(fir_output(sample_in_i));
          for (int k = MAX_TAPS - 2; k > 0; k--) history[k] = history[k-1];
          history[0] = sample_in_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected item: sample_out %0d clipped %0b", sample_out_i, clipped_i);
          fails++;
        end else begin
          exp_out = expected_outputs.pop_front();
          if (sample_out_i !== exp_out.sample) begin
            $error("sample_out: expected %0d, got %0d", exp_out.sample, sample_out_i);
            fails++;
          end
          if (clipped_i !== exp_out.clipped) begin
            $error("clipped: expected %0b, got %0b", exp_out.clipped, clipped_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_outputs.size();
    end
  end

endmodule

FILE: dv/tb_fir_filter_direct_form_top.sv
// tb_fir_filter_direct_form_top: stimulus, clock, reset and verdict for the fir filter.
// Depends on firdf_pkg, fir_filter_direct_form_top and fir_filter_direct_form_checker.
`timescale 1ns / 1ps

module tb_fir_filter_direct_form_top;
  import firdf_pkg::*;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic [TAPCNT_W-1:0]        cfg_wdata_i  = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic                       action_i     = ACT_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_in_i  = '0;
  logic [IDX_W-1:0]           coef_index_i = '0;
  logic signed [COEF_W-1:0]   coef_value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       clipped_o;

  int fail_count;
  int pending;
  int stall_run = 0;
  bit steady    = 1'b0;  // no gaps on either side while set

  int unsigned tap_plan [10] = '{32, 0, 1, 63, 33, 15, 2, 31, 8, 20};

  always #6 clk_i = ~clk_i;

  fir_filter_direct_form_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  fir_filter_direct_form_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .action_i     (action_i),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_i (sample_out_o),
    .clipped_i    (clipped_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver alternates between ready stretches and stalls
  always @(posedge clk_i) begin
    if (steady) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run == 0) begin
      out_stall_i <= ~out_stall_i;
      stall_run   <= out_stall_i ? $urandom_range(0, 6) : pick_gap();
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  task automatic send_item(input firdf_action_e act, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] coef,
                           input int gap);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    sample_in_i  <= smp;
    coef_index_i <= idx;
    coef_value_i <= coef;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_taps(input logic [TAPCNT_W-1:0] taps);
    drain();
    cfg_wdata_i <= taps;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input int gap);
    send_item(ACT_SAMPLE, smp, IDX_W'($urandom), COEF_W'($urandom), gap);
  endtask

  task automatic send_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] coef,
                           input int gap);
    send_item(ACT_LOAD, SAMPLE_W'($urandom), idx, coef, gap);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] smp;
    logic [COEF_W-1:0]   coef;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset tap count
    send_coef(5'd0, 16'h7FFF, 0);
    send_coef(5'd1, 16'h8000, 0);
    send_coef(5'd31, 16'hFFFF, 0);
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);   // clips low
    send_sample(SAMPLE_MAX, 1);   // clips high
    send_sample(12'h000, 0);
    send_coef(5'd0, 16'h0003, 0);
    send_coef(5'd1, 16'h0000, 0);
    send_sample(12'hFFF, 0);      // tiny negative sum truncates to zero
    send_sample(12'h001, 2);
    send_coef(5'd0, 16'h8000, 0);
    send_sample(SAMPLE_MIN, 0);   // just past the top of the range
    send_sample(SAMPLE_MAX, 0);
    send_coef(5'd14, 16'h4000, 0);
    send_coef(5'd1, 16'h5555, 0);
    send_sample(12'hAAA, 0);
    send_sample(12'h555, 0);

    set_taps(6'd0);               // zero taps
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);
    set_taps(6'd63);              // more than the maximum
    send_coef(5'd31, 16'h7FFF, 0);
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);

    foreach (tap_plan[p]) begin
      set_taps(tap_plan[p][TAPCNT_W-1:0]);
      steady <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(0, 99) == 0) drain();
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: coef = COEF_W'($urandom);
            1: coef = COEF_W'($urandom_range(0, 4095) - 2048);
            2: coef = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: coef = '0;
          endcase
          send_coef(IDX_W'($urandom), coef, pick_gap());
        end else begin
          case ($urandom_range(0, 7))
            0: smp = SAMPLE_MAX;
            1: smp = SAMPLE_MIN;
            2: smp = SAMPLE_W'($urandom_range(0, 15) - 8);
            default: smp = SAMPLE_W'($urandom);
          endcase
          send_sample(smp, pick_gap());
        end
      end
    end

    steady <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
